// ===== hdl/led_blink_pattern_controller_top_macros.svh =====
// Assertion macros for the LED blink pattern controller checker.
// Used only by the port checker; relies on nothing else.
`ifndef LED_BLINK_PATTERN_CONTROLLER_TOP_MACROS_SVH
`define LED_BLINK_PATTERN_CONTROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LBPC_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lbpc checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is high.
`define LBPC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lbpc checker: next-cycle property failed");

`endif

// ===== hdl/lbpc_pkg.sv =====
// Shared types and constants of the LED blink pattern controller.
// No dependencies; imported by every module of the block.
`default_nettype none

package lbpc_pkg;

  localparam int TABLE_DEPTH   = 8;
  localparam int DURATION_BITS = 16;

  localparam int CUR_W     = $clog2(TABLE_DEPTH);
  localparam int LEN_W     = $clog2(TABLE_DEPTH + 1);
  localparam int ELAPSED_W = DURATION_BITS + 1;

  localparam int CMD_W   = 3;
  localparam int IDX_W   = 3;
  localparam int VALUE_W = 16;
  localparam int PLEN_W  = 4;
  localparam int MODE_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 3'd0,
    CMD_ON     = 3'd1,
    CMD_OFF    = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4,
    CMD_START  = 3'd5,
    CMD_CLEAR  = 3'd6,
    CMD_LOAD   = 3'd7
  } cmd_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_OFF   = 2'd0,
    MODE_ON    = 2'd1,
    MODE_BLINK = 2'd2
  } mode_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [IDX_W-1:0]  entry_index;
    logic [VALUE_W-1:0] entry_value;
    logic [PLEN_W-1:0] pattern_length;
  } item_t;

  typedef struct packed {
    logic  pin_level;
    mode_t mode;
    logic  is_off;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/lbpc_in_reg.sv =====
// Input register of the LED blink pattern controller.
// Holds one accepted item until the core takes it; uses lbpc_pkg.
`default_nettype none

module lbpc_in_reg (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  lbpc_pkg::item_t      in_item,
  output logic                 hold_valid,
  output lbpc_pkg::item_t      hold_item,
  input  wire logic            take
);
  import lbpc_pkg::*;

  // The register frees up in the same cycle that the core takes its item.
  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lbpc_core.sv =====
// State update of the LED blink pattern controller: mode, blink phase,
// cursor, elapsed count and the duration table. Uses lbpc_pkg.
`default_nettype none

module lbpc_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        fire,
  input  lbpc_pkg::item_t  item,
  output lbpc_pkg::result_t result
);
  import lbpc_pkg::*;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  mode_t                  mode_reg, mode_reg_next;
  mode_t                  saved_mode, saved_mode_next;
  logic                   pin_out, pin_out_next;
  logic                   phase_on, phase_on_next;
  logic [CUR_W-1:0]       cursor, cursor_next;
  logic [LEN_W-1:0]       length_in_use, length_in_use_next;
  logic                   started, started_next;
  logic [ELAPSED_W-1:0]   elapsed_ms, elapsed_ms_next;

  logic [DURATION_BITS-1:0] pattern_table [TABLE_DEPTH];

  logic [ELAPSED_W-1:0]   elapsed_inc;
  logic [DURATION_BITS-1:0] limit;
  logic [LEN_W-1:0]       cursor_plus;
  logic [LEN_W-1:0]       length_clamped;
  logic                   table_wr;

  assign limit       = pattern_table[cursor];
  assign cursor_plus = LEN_W'(cursor) + LEN_W'(1);
  assign elapsed_inc = (started && (elapsed_ms != ELAPSED_MAX)) ?
                       elapsed_ms + ELAPSED_W'(1) : elapsed_ms;

  always_comb begin
    if (item.pattern_length == '0) begin
      length_clamped = LEN_W'(1);
    end else if (int'(item.pattern_length) > TABLE_DEPTH) begin
      length_clamped = LEN_W'(TABLE_DEPTH);
    end else begin
      length_clamped = LEN_W'(item.pattern_length);
    end
  end

  assign table_wr = fire && (item.cmd == CMD_LOAD) &&
                    (int'(item.entry_index) < TABLE_DEPTH);

  always_comb begin
    mode_reg_next      = mode_reg;
    saved_mode_next    = saved_mode;
    pin_out_next       = pin_out;
    phase_on_next      = phase_on;
    cursor_next        = cursor;
    length_in_use_next = length_in_use;
    started_next       = started;
    elapsed_ms_next    = elapsed_ms;

    unique case (item.cmd)
      CMD_TICK: begin
        elapsed_ms_next = elapsed_inc;
        if (mode_reg == MODE_BLINK) begin
          if (!started) begin
            // The first tick after a start lights the pin.
            phase_on_next   = 1'b1;
            pin_out_next    = 1'b1;
            started_next    = 1'b1;
            elapsed_ms_next = '0;
          end else if (elapsed_inc > ELAPSED_W'(limit)) begin
            phase_on_next   = !phase_on;
            pin_out_next    = !phase_on;
            cursor_next     = (cursor_plus >= length_in_use) ? '0 : CUR_W'(cursor_plus);
            elapsed_ms_next = '0;
          end
        end
      end
      CMD_ON: begin
        if (mode_reg == MODE_BLINK) begin
          cursor_next     = '0;
          phase_on_next   = 1'b0;
          started_next    = 1'b0;
          saved_mode_next = MODE_BLINK;
        end
        pin_out_next  = 1'b1;
        mode_reg_next = MODE_ON;
      end
      CMD_OFF: begin
        pin_out_next    = 1'b0;
        saved_mode_next = mode_reg;
        mode_reg_next   = MODE_OFF;
      end
      CMD_PAUSE: begin
        if (mode_reg == MODE_BLINK) begin
          pin_out_next    = 1'b0;
          cursor_next     = '0;
          phase_on_next   = 1'b0;
          started_next    = 1'b0;
          saved_mode_next = MODE_BLINK;
          mode_reg_next   = MODE_OFF;
        end
      end
      CMD_RESUME: begin
        if (saved_mode == MODE_BLINK) begin
          mode_reg_next   = MODE_BLINK;
          saved_mode_next = MODE_OFF;
        end
      end
      CMD_START: begin
        // Starting from on mode passes through off first.
        if (mode_reg == MODE_ON) begin
          pin_out_next    = 1'b0;
          saved_mode_next = MODE_ON;
        end
        length_in_use_next = length_clamped;
        cursor_next        = '0;
        started_next       = 1'b0;
        mode_reg_next      = MODE_BLINK;
      end
      CMD_CLEAR: begin
        phase_on_next      = 1'b0;
        started_next       = 1'b0;
        saved_mode_next    = MODE_OFF;
        mode_reg_next      = MODE_OFF;
        length_in_use_next = LEN_W'(1);
      end
      CMD_LOAD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg      <= MODE_OFF;
      saved_mode    <= MODE_OFF;
      pin_out       <= 1'b0;
      phase_on      <= 1'b0;
      cursor        <= '0;
      length_in_use <= LEN_W'(1);
      started       <= 1'b0;
      elapsed_ms    <= '0;
    end else if (fire) begin
      mode_reg      <= mode_reg_next;
      saved_mode    <= saved_mode_next;
      pin_out       <= pin_out_next;
      phase_on      <= phase_on_next;
      cursor        <= cursor_next;
      length_in_use <= length_in_use_next;
      started       <= started_next;
      elapsed_ms    <= elapsed_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (table_wr) begin
      pattern_table[CUR_W'(item.entry_index)] <= DURATION_BITS'(item.entry_value);
    end
  end

  assign result.pin_level = pin_out_next;
  assign result.mode      = mode_reg_next;
  assign result.is_off    = (mode_reg_next == MODE_OFF);

endmodule

`default_nettype wire

// ===== hdl/lbpc_out_reg.sv =====
// Result register of the LED blink pattern controller.
// Holds one result until the consumer takes it; uses lbpc_pkg.
`default_nettype none

module lbpc_out_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  lbpc_pkg::result_t  res_in,
  output logic               can_load,
  output logic               out_valid,
  input  wire logic          out_ready,
  output lbpc_pkg::result_t  res_out
);
  import lbpc_pkg::*;

  assign can_load = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_out <= res_in;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/led_blink_pattern_controller_top.sv =====
// LED blink pattern controller: one LED pin in off, on or blink mode, with
// an eight-slot duration table for blink mode. Each accepted item is a
// command (tick, on, off, pause, resume, start blink, clear, load entry) and
// gives exactly one result: the pin level and mode after that command. The
// block takes one item per clock cycle while the consumer keeps taking
// results; the state update works out a whole command combinationally
// between the input register and the result register, and the result is
// registered in the result register. Items keep flowing while a result
// waits, as long as the input register has room. Table slots must be loaded
// before blink mode reads them.
`default_nettype none

module led_blink_pattern_controller_top (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [lbpc_pkg::CMD_W-1:0]  cmd,
  input  wire logic [lbpc_pkg::IDX_W-1:0]  entry_index,
  input  wire logic [lbpc_pkg::VALUE_W-1:0] entry_value,
  input  wire logic [lbpc_pkg::PLEN_W-1:0] pattern_length,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             pin_level,
  output logic [lbpc_pkg::MODE_W-1:0]      mode,
  output logic                             is_off
);
  import lbpc_pkg::*;

  item_t   in_item;
  item_t   hold_item;
  logic    hold_valid;
  logic    can_load;
  logic    take;
  result_t core_result;
  result_t res_out;

  assign in_item.cmd            = cmd_t'(cmd);
  assign in_item.entry_index    = entry_index;
  assign in_item.entry_value    = entry_value;
  assign in_item.pattern_length = pattern_length;

  assign take = hold_valid && can_load;

  lbpc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take)
  );

  lbpc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (take),
    .item   (hold_item),
    .result (core_result)
  );

  lbpc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .res_in    (core_result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_out   (res_out)
  );

  assign pin_level = res_out.pin_level;
  assign mode      = MODE_W'(res_out.mode);
  assign is_off    = res_out.is_off;

endmodule

`default_nettype wire

// ===== hdl/lbpc_checker.sv =====
// Port checker for the LED blink pattern controller, bound to the top level.
// Uses lbpc_pkg and the assertion macros header.
`default_nettype none

`include "led_blink_pattern_controller_top_macros.svh"

module lbpc_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        pin_level,
  input wire logic [lbpc_pkg::MODE_W-1:0] mode,
  input wire logic                        is_off
);
  import lbpc_pkg::*;

  // A result held back by the consumer must not change.
  `LBPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(pin_level) && $stable(mode) && $stable(is_off))

  // The off flag agrees with the reported mode whenever a result is offered.
  `LBPC_ASSERT_NOW(a_off_flag, clk, rst, out_valid, is_off == (mode == MODE_OFF))

  // Only an on command enters on mode, and it lights the pin.
  `LBPC_ASSERT_NOW(a_on_lit, clk, rst, out_valid && (mode == MODE_ON), pin_level)

  // No result is offered straight after reset.
  `LBPC_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !out_valid)

endmodule

bind led_blink_pattern_controller_top lbpc_checker u_lbpc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .pin_level (pin_level),
  .mode      (mode),
  .is_off    (is_off)
);

`default_nettype wire

// ===== test/tb_led_blink_pattern_controller_top.sv =====
// Self-checking testbench for led_blink_pattern_controller_top: directed and random
// command items, predicted by a cycle-free model of the LED controller.
// Depends on lbpc_pkg and the controller RTL only.
module tb_led_blink_pattern_controller_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbpc_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 1760;
  localparam int MAX_REPORTS   = 200;
  localparam logic [ELAPSED_W-1:0] ELAPSED_FULL = '1;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [CMD_W-1:0]    cmd = '0;
  logic [IDX_W-1:0]    entry_index = '0;
  logic [VALUE_W-1:0]  entry_value = '0;
  logic [PLEN_W-1:0]   pattern_length = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                pin_level;
  logic [MODE_W-1:0]   mode;
  logic                is_off;

  // Predicted controller state, at reset values.
  mode_t               led_mode = MODE_OFF;
  mode_t               held_mode = MODE_OFF;
  logic                pin_state = 1'b0;
  logic                phase_high = 1'b0;
  logic [CUR_W-1:0]    slot_cursor = '0;
  logic [LEN_W-1:0]    active_length = LEN_W'(1);
  logic                running = 1'b0;
  logic [ELAPSED_W-1:0] elapsed_count = '0;
  logic [VALUE_W-1:0]  led_durations [TABLE_DEPTH];

  result_t             expected_q [$];
  result_t             want;
  int                  errors = 0;
  int                  items_sent = 0;
  int                  results_seen = 0;
  int                  toggle_count = 0;
  int                  quiet_cycles = 0;
  int                  burst_left = 0;
  int                  ready_left = 0;
  int                  stall_left = 0;
  bit                  steady_flow = 1'b0;

  led_blink_pattern_controller_top i_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .cmd            (cmd),
    .entry_index    (entry_index),
    .entry_value    (entry_value),
    .pattern_length (pattern_length),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .pin_level      (pin_level),
    .mode           (mode),
    .is_off         (is_off)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void stop_blink();
    if (led_mode == MODE_BLINK) begin
      pin_state   = 1'b0;
      slot_cursor = '0;
      phase_high  = 1'b0;
      running     = 1'b0;
      held_mode   = MODE_BLINK;
      led_mode    = MODE_OFF;
    end
  endfunction

  function automatic void go_dark();
    pin_state = 1'b0;
    held_mode = led_mode;
    led_mode  = MODE_OFF;
  endfunction

  function automatic result_t predict_led(cmd_t op, logic [IDX_W-1:0] slot,
                                          logic [VALUE_W-1:0] value,
                                          logic [PLEN_W-1:0] plen);
    result_t r;
    logic [LEN_W-1:0] nxt;
    logic [PLEN_W-1:0] n;
    case (op)
      CMD_TICK: begin
        // The elapsed count keeps running from the first tick after a start, whatever the mode.
        if (running && elapsed_count != ELAPSED_FULL) begin
          elapsed_count = elapsed_count + ELAPSED_W'(1);
        end
        if (led_mode == MODE_BLINK) begin
          if (!running) begin
            phase_high    = 1'b1;
            pin_state     = 1'b1;
            running       = 1'b1;
            elapsed_count = '0;
          end else if (elapsed_count > {1'b0, led_durations[slot_cursor]}) begin
            phase_high    = !phase_high;
            pin_state     = phase_high;
            nxt           = LEN_W'(slot_cursor);
            nxt           = nxt + LEN_W'(1);
            slot_cursor   = (nxt >= active_length) ? '0 : nxt[CUR_W-1:0];
            elapsed_count = '0;
            toggle_count++;
          end
        end
      end
      CMD_ON: begin
        stop_blink();
        pin_state = 1'b1;
        led_mode  = MODE_ON;
      end
      CMD_OFF: go_dark();
      CMD_PAUSE: stop_blink();
      CMD_RESUME: begin
        if (held_mode == MODE_BLINK) begin
          led_mode  = MODE_BLINK;
          held_mode = MODE_OFF;
        end
      end
      CMD_START: begin
        if (led_mode == MODE_ON) go_dark();
        n = plen;
        if (n == '0) n = PLEN_W'(1);
        if (n > TABLE_DEPTH) n = PLEN_W'(TABLE_DEPTH);
        active_length = n;
        slot_cursor   = '0;
        running       = 1'b0;
        led_mode      = MODE_BLINK;
      end
      CMD_CLEAR: begin
        phase_high    = 1'b0;
        running       = 1'b0;
        held_mode     = MODE_OFF;
        led_mode      = MODE_OFF;
        active_length = LEN_W'(1);
      end
      CMD_LOAD: led_durations[slot] = value;
      default: ;
    endcase
    r.pin_level = pin_state;
    r.mode      = led_mode;
    r.is_off    = (led_mode == MODE_OFF);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sending items
  // ---------------------------------------------------------------------------
  task automatic send_item(input cmd_t op, input logic [IDX_W-1:0] slot,
                           input logic [VALUE_W-1:0] value,
                           input logic [PLEN_W-1:0] plen);
    int gap;
    @(negedge clk);
    if (!steady_flow) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 24);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      burst_left--;
    end
    in_valid       <= 1'b1;
    cmd            <= op;
    entry_index    <= slot;
    entry_value    <= value;
    pattern_length <= plen;
    do @(posedge clk); while (!in_ready);
    expected_q.push_back(predict_led(op, slot, value, plen));
    items_sent++;
  endtask

  // Fields other than the command carry noise; the block must ignore them.
  task automatic send_plain(input cmd_t op);
    send_item(op, IDX_W'($urandom_range(0, 7)), VALUE_W'($urandom_range(0, 65535)),
              PLEN_W'($urandom_range(0, 15)));
  endtask

  task automatic load_random_slot();
    logic [VALUE_W-1:0] value;
    // Short durations keep the blink pattern moving; now and then a long one.
    value = ($urandom_range(0, 24) == 0) ? VALUE_W'($urandom_range(0, 65535)) :
                                           VALUE_W'($urandom_range(0, 4));
    send_item(CMD_LOAD, IDX_W'($urandom_range(0, 7)), value, PLEN_W'($urandom_range(0, 15)));
  endtask

  task automatic start_random_blink();
    logic [PLEN_W-1:0] plen;
    plen = ($urandom_range(0, 5) == 0) ? PLEN_W'($urandom_range(0, 15)) :
                                         PLEN_W'($urandom_range(1, 8));
    send_item(CMD_START, IDX_W'($urandom_range(0, 7)), VALUE_W'($urandom_range(0, 65535)),
              plen);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver stalls and result checking
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (steady_flow) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if (ready_left > 0) begin
      out_ready <= 1'b1;
      ready_left--;
    end else begin
      ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6);
      stall_left = $urandom_range(1, 5);
      out_ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [1:0] expected, logic [1:0] actual);
    if (actual !== expected) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual pin %0b mode %0d is_off %0b",
                 $time, pin_level, mode, is_off);
      end else begin
        want = expected_q.pop_front();
        check_field("pin_level", {1'b0, want.pin_level}, {1'b0, pin_level});
        check_field("mode", want.mode, mode);
        check_field("is_off", {1'b0, want.is_off}, {1'b0, is_off});
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Commands outside blink mode, before any duration is loaded.
  task automatic test_steady_modes();
    send_item(CMD_TICK, '0, '0, '0);
    send_item(CMD_ON, '1, '1, '1);
    send_plain(CMD_OFF);
    send_plain(CMD_RESUME);
    send_plain(CMD_PAUSE);
    send_plain(CMD_CLEAR);
  endtask

  // Every slot is written here so that blink mode never reads an empty one.
  task automatic test_table_load();
    send_item(CMD_LOAD, 3'd7, 16'hFFFF, '0);
    for (int i = 0; i < TABLE_DEPTH; i++)
      send_item(CMD_LOAD, IDX_W'(i), VALUE_W'(i % 3), PLEN_W'($urandom_range(0, 15)));
  endtask

  task automatic test_blink_entry();
    send_item(CMD_START, '0, '0, 4'd0);   // zero length behaves as one
    send_plain(CMD_TICK);                 // first tick lights the pin
    send_plain(CMD_TICK);
    send_plain(CMD_TICK);
    send_plain(CMD_ON);                   // on from blink pauses first
    send_item(CMD_START, '1, '1, 4'd15);  // from on: off first, length saturates
    send_plain(CMD_TICK);
    send_plain(CMD_TICK);
    send_plain(CMD_CLEAR);                // pin and cursor stay put
    send_plain(CMD_RESUME);               // nothing saved, so ignored
  endtask

  // The elapsed count keeps running while off, so the first tick after a
  // resume must toggle at once.
  task automatic test_resume_after_off();
    steady_flow = 1'b1;
    send_item(CMD_LOAD, '0, VALUE_W'(3), '0);
    send_item(CMD_START, '0, '0, PLEN_W'(1));
    send_plain(CMD_TICK);
    send_plain(CMD_OFF);
    repeat (6) send_plain(CMD_TICK);
    send_plain(CMD_RESUME);
    send_plain(CMD_TICK);
    send_item(CMD_LOAD, '0, VALUE_W'(1), '0);
    steady_flow = 1'b0;
  endtask

  task automatic test_random_traffic();
    int first;
    int roll;
    bit drained;
    cmd_t op;
    first   = items_sent;
    drained = 1'b0;
    while (items_sent - first < RANDOM_ITEMS) begin
      if (!drained && items_sent - first >= RANDOM_ITEMS / 2) begin
        wait_for_results();
        drained = 1'b1;
      end
      if ($urandom_range(0, 9) < 7) begin
        // A well-formed blink session with interruptions along the way.
        repeat ($urandom_range(0, 2)) load_random_slot();
        start_random_blink();
        repeat ($urandom_range(8, 50)) begin
          roll = $urandom_range(0, 99);
          if (roll < 74) send_plain(CMD_TICK);
          else if (roll < 80) send_plain(CMD_OFF);
          else if (roll < 87) send_plain(CMD_RESUME);
          else if (roll < 91) send_plain(CMD_PAUSE);
          else if (roll < 94) send_plain(CMD_ON);
          else if (roll < 96) send_plain(CMD_CLEAR);
          else if (roll < 99) load_random_slot();
          else start_random_blink();
        end
      end else begin
        repeat ($urandom_range(3, 10)) begin
          op = cmd_t'(CMD_W'($urandom_range(0, 7)));
          if (op == CMD_LOAD) load_random_slot();
          else if (op == CMD_START) start_random_blink();
          else send_plain(op);
        end
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_steady_modes();
    test_table_load();
    test_blink_entry();
    wait_for_results();
    test_resume_after_off();
    test_random_traffic();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("Run covered %0d items and %0d results across all commands, with %0d blink toggles",
             items_sent, results_seen, toggle_count);
    $display("including a resume after off that toggles at once; %0d mismatches.", errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
